// ----- design/tsac_pkg.sv -----
// tsac_pkg: shared types and constants of the ttl set-associative cache
// no dependencies
`timescale 1ns / 1ps

package tsac_pkg;

  localparam logic [31:0] HASH_PLAYER = 32'd2654435761;
  localparam logic [31:0] HASH_TEAM   = 32'd2246822519;
  localparam logic [31:0] HASH_DAY    = 32'd3266489917;
  localparam logic [31:0] HASH_LEAGUE = 32'd668265263;
  localparam int          FOLD_SHIFT  = 16;
  localparam logic [31:0] TTL_RESET   = 32'd2000;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_STORE  = 1'b1;

  // one way of a set as held in the row memory
  typedef struct packed {
    logic        valid;
    logic [31:0] team;
    logic [31:0] player;
    logic [31:0] day;
    logic [31:0] league;
    logic [63:0] tag;
    logic [31:0] gen;
    logic [31:0] stamp;
    logic        asian;
    logic [7:0]  extra;
    logic [7:0]  slot_kind;
    logic [31:0] injured;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // lookup outcome handed from the match logic to the top level
  typedef struct packed {
    logic        hit;
    logic [7:0]  slot_kind;
    logic [31:0] injured;
    logic [7:0]  extra;
  } lookup_res_t;

endpackage

// ----- design/tsac_ram.sv -----
// tsac_ram: generic single write port ram with one registered read port
// no dependencies
`timescale 1ns / 1ps

module tsac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/tsac_hash.sv -----
// tsac_hash: registered multiplicative key hash and set index fold
// depends on tsac_pkg
`timescale 1ns / 1ps

module tsac_hash #(
  parameter int ENTRIES = 4096,
  parameter int WAYS    = 4
) (
  input  logic                                clk,
  input  logic                                load,
  input  logic [31:0]                         team,
  input  logic [31:0]                         player,
  input  logic [31:0]                         day,
  input  logic [31:0]                         league,
  output logic [$clog2(ENTRIES/WAYS)-1:0]     set_idx
);

  localparam int SET_W   = $clog2(ENTRIES / WAYS);
  localparam int WAY_LOG = $clog2(WAYS);

  logic [31:0] p_team_r, p_player_r, p_day_r, p_league_r;
  logic [31:0] p_team_nxt, p_player_nxt, p_day_nxt, p_league_nxt;
  logic [31:0] h_mix, h_fold;

  // low 32 bits of each product only
  assign p_player_nxt = player * tsac_pkg::HASH_PLAYER;
  assign p_team_nxt   = team * tsac_pkg::HASH_TEAM;
  assign p_day_nxt    = day * tsac_pkg::HASH_DAY;
  assign p_league_nxt = league * tsac_pkg::HASH_LEAGUE;

  always_ff @(posedge clk) begin
    if (load) begin
      p_team_r   <= p_team_nxt;
      p_player_r <= p_player_nxt;
      p_day_r    <= p_day_nxt;
      p_league_r <= p_league_nxt;
    end
  end

  assign h_mix   = p_player_r ^ p_team_r ^ p_day_r ^ p_league_r;
  assign h_fold  = h_mix ^ (h_mix >> tsac_pkg::FOLD_SHIFT);
  assign set_idx = h_fold[WAY_LOG +: SET_W];

endmodule

// ----- design/tsac_match.sv -----
// tsac_match: way compare, lookup hit select and store victim choice for one set
// depends on tsac_pkg
`timescale 1ns / 1ps

module tsac_match #(
  parameter int WAYS = 4
) (
  input  tsac_pkg::entry_t [WAYS-1:0]           row,
  input  logic [31:0]                           team,
  input  logic [31:0]                           player,
  input  logic [31:0]                           day,
  input  logic [31:0]                           league,
  input  logic [63:0]                           tag,
  input  logic                                  asian,
  input  logic [31:0]                           gen,
  input  logic [31:0]                           now_ms,
  input  logic [31:0]                           ttl_ms,
  output tsac_pkg::lookup_res_t                 res,
  output logic [(WAYS > 1 ? $clog2(WAYS) : 1)-1:0] victim
);

  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic [WAYS-1:0] key_eq;
  logic [WAYS-1:0] live;
  logic [31:0]     age [WAYS];

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      key_eq[w] = row[w].team == team && row[w].player == player &&
                  row[w].day == day && row[w].league == league && row[w].tag == tag;
      age[w]    = now_ms - row[w].stamp;
      live[w]   = row[w].valid && key_eq[w] && row[w].asian == asian &&
                  row[w].gen == gen && row[w].stamp != 32'd0 && age[w] <= ttl_ms;
    end
  end

  // first live way wins
  always_comb begin
    logic found;
    found = 1'b0;
    res   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!found && live[w]) begin
        found         = 1'b1;
        res.hit       = 1'b1;
        res.slot_kind = row[w].slot_kind;
        res.injured   = row[w].injured;
        res.extra     = row[w].extra;
      end
    end
  end

  // first empty or same-key way, else oldest stamp, lowest way on ties
  always_comb begin
    logic done;
    done   = 1'b0;
    victim = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!done) begin
        if (!row[w].valid || key_eq[w]) begin
          victim = WAY_W'(w);
          done   = 1'b1;
        end else if (row[w].stamp < row[victim].stamp) begin
          victim = WAY_W'(w);
        end
      end
    end
  end

endmodule

// ----- design/ttl_set_associative_cache_core.sv -----
// ttl_set_associative_cache_core: top level of the ttl set-associative cache
// depends on tsac_pkg, tsac_ram, tsac_hash and tsac_match
`timescale 1ns / 1ps

// usage:
// - input channel (in_*): one request per item, in_kind selects lookup or store.
// - output channel (out_*): one result per lookup, none per store; a miss
//   returns out_hit low with all data fields zero.
// - cfg channel: writes ttl_ms, always ready; write only while the block is idle.
// - a request passes through accept (hash products registered), set row
//   read from the row memory, then compare and write back; one request is
//   in flight at a time.
// - lookup result: loaded into the output register at the end of the compare step.
// - the result sits in an output register; the next request is accepted
//   while it waits. a second lookup holds in its compare step until the
//   receiver takes the first result.
// - after reset a clearing pass writes every set row empty, ENTRIES/WAYS
//   rows (1024 by default), with in_ready low; ttl_ms resets to 2000.
module ttl_set_associative_cache_core #(
  parameter int ENTRIES = 4096,
  parameter int WAYS    = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [31:0] in_team_key,
  input  logic [31:0] in_player_key,
  input  logic [31:0] in_day_key,
  input  logic [31:0] in_league_key,
  input  logic [63:0] in_object_tag,
  input  logic        in_asian_flag,
  input  logic [31:0] in_replacement_gen,
  input  logic [31:0] in_now_ms,
  input  logic [7:0]  in_extra_count,
  input  logic [7:0]  in_slot_kind,
  input  logic [31:0] in_injured_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic [7:0]  out_found_slot_kind,
  output logic [31:0] out_found_injured_id,
  output logic [7:0]  out_found_extra_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int SETS  = ENTRIES / WAYS;
  localparam int SET_W = $clog2(SETS);
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W = WAYS * tsac_pkg::ENTRY_W;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_CMP} state_t;

  state_t      state_r;
  logic [SET_W-1:0] clr_cnt_r;
  logic [31:0] ttl_r;

  logic        kind_r;
  logic [31:0] team_r, player_r, day_r, league_r, gen_r, now_r, injured_r;
  logic [63:0] tag_r;
  logic        asian_r;
  logic [7:0]  extra_r, skind_r;

  logic                  out_valid_r;
  tsac_pkg::lookup_res_t out_res_r;

  logic                              in_fire;
  logic [SET_W-1:0]                  set_idx;
  logic [ROW_W-1:0]                  rdata;
  tsac_pkg::entry_t [WAYS-1:0]       row, row_nxt;
  tsac_pkg::entry_t                  new_entry;
  tsac_pkg::lookup_res_t             res;
  logic [WAY_W-1:0]                  victim;
  logic                              store_ok;
  logic                              store_we;
  logic                              out_load;
  logic                              ram_we;
  logic [SET_W-1:0]                  ram_waddr;
  logic [ROW_W-1:0]                  ram_wdata;

  assign in_ready  = state_r == S_IDLE;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  tsac_hash #(.ENTRIES(ENTRIES), .WAYS(WAYS)) u_hash (
    .clk     (clk),
    .load    (in_fire),
    .team    (in_team_key),
    .player  (in_player_key),
    .day     (in_day_key),
    .league  (in_league_key),
    .set_idx (set_idx)
  );

  tsac_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (set_idx),
    .rdata (rdata)
  );

  assign row = rdata;

  tsac_match #(.WAYS(WAYS)) u_match (
    .row    (row),
    .team   (team_r),
    .player (player_r),
    .day    (day_r),
    .league (league_r),
    .tag    (tag_r),
    .asian  (asian_r),
    .gen    (gen_r),
    .now_ms (now_r),
    .ttl_ms (ttl_r),
    .res    (res),
    .victim (victim)
  );

  always_comb begin
    new_entry.valid     = 1'b1;
    new_entry.team      = team_r;
    new_entry.player    = player_r;
    new_entry.day       = day_r;
    new_entry.league    = league_r;
    new_entry.tag       = tag_r;
    new_entry.gen       = gen_r;
    new_entry.stamp     = now_r;
    new_entry.asian     = asian_r;
    new_entry.extra     = extra_r;
    new_entry.slot_kind = skind_r;
    new_entry.injured   = injured_r;
    row_nxt             = row;
    row_nxt[victim]     = new_entry;
  end

  // stores with an empty team, player or tag leave the set untouched
  assign store_ok = team_r != 32'd0 && player_r != 32'd0 && tag_r != 64'd0;
  assign store_we = state_r == S_CMP && kind_r == tsac_pkg::KIND_STORE && store_ok;
  assign out_load = state_r == S_CMP && kind_r == tsac_pkg::KIND_LOOKUP &&
                    (!out_valid_r || out_ready);

  assign ram_we    = state_r == S_CLEAR || store_we;
  assign ram_waddr = (state_r == S_CLEAR) ? clr_cnt_r : set_idx;
  assign ram_wdata = (state_r == S_CLEAR) ? '0 : ROW_W'(row_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      ttl_r       <= tsac_pkg::TTL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ttl_r <= cfg_data;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == SET_W'(SETS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (kind_r == tsac_pkg::KIND_STORE) begin
            state_r <= S_IDLE;
          end else if (out_load) begin
            out_valid_r <= 1'b1;
            out_res_r   <= res;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // request fields held for the whole item
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r    <= in_kind;
      team_r    <= in_team_key;
      player_r  <= in_player_key;
      day_r     <= in_day_key;
      league_r  <= in_league_key;
      tag_r     <= in_object_tag;
      asian_r   <= in_asian_flag;
      gen_r     <= in_replacement_gen;
      now_r     <= in_now_ms;
      extra_r   <= in_extra_count;
      skind_r   <= in_slot_kind;
      injured_r <= in_injured_id;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_hit               = out_res_r.hit;
  assign out_found_slot_kind   = out_res_r.slot_kind;
  assign out_found_injured_id  = out_res_r.injured;
  assign out_found_extra_count = out_res_r.extra;

  a_fire_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_READ)
    else $error("accepted request did not move to the row read");

  a_result_from_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_CMP && kind_r == tsac_pkg::KIND_LOOKUP))
    else $error("result raised outside a lookup compare");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_READ) |-> !ram_we)
    else $error("row memory written outside clear or compare");

endmodule
